FILE: hw/rtl/tem_pkg.sv
`default_nettype none

package tem_pkg;

   localparam int STATUS_W  = 2;
   localparam int VOLT_W    = 16;
   localparam int CURR_W    = 18;
   localparam int TIME_W    = 32;
   localparam int ENERGY_W  = 63;
   localparam int CHARGE_W  = 64;

   localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
   localparam logic [CHARGE_W-1:0] CHARGE_MAX = {1'b0, {(CHARGE_W-1){1'b1}}};
   localparam logic [CHARGE_W-1:0] CHARGE_MIN = {1'b1, {(CHARGE_W-1){1'b0}}};

   // request opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_PRIMED  = 2'd0,
      ST_INTEG   = 2'd1,
      ST_SKIP    = 2'd2,
      ST_CLEARED = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POWER_S,
      S_POWER_B,
      S_SUMS,
      S_MUL_LO,
      S_MUL_HI,
      S_ADD,
      S_ACCUM,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

FILE: hw/rtl/trapezoid_energy_meter.sv
// An integrating sample runs S_POWER_S, S_POWER_B, S_SUMS, then S_MUL_LO, S_MUL_HI, S_ADD
// and S_ACCUM per area, then S_DONE; a first or zero-interval sample jumps from S_SUMS, a
// clear from S_IDLE, to S_DONE. No new sample is taken until the result is in the output
// register. The four areas share one 18x32 multiplier and 63/64-bit saturating adders.
// Reset (synchronous, active high) zeroes all totals and history and drops rsp_valid.
`default_nettype none

module trapezoid_energy_meter (
   input  wire                                 clock,
   input  wire                                 reset,
   // sample transaction
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire                                 req_op,
   input  wire  [tem_pkg::VOLT_W-1:0]          req_battery_voltage,
   input  wire  signed [tem_pkg::CURR_W-1:0]   req_battery_current,
   input  wire  [tem_pkg::VOLT_W-1:0]          req_solar_voltage,
   input  wire  signed [tem_pkg::CURR_W-1:0]   req_solar_current,
   input  wire  [tem_pkg::TIME_W-1:0]          req_sample_time,
   // result transaction
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic [tem_pkg::STATUS_W-1:0]        rsp_status,
   output logic [tem_pkg::ENERGY_W-1:0]        rsp_solar_energy,
   output logic [tem_pkg::ENERGY_W-1:0]        rsp_charge_energy,
   output logic [tem_pkg::ENERGY_W-1:0]        rsp_discharge_energy,
   output logic signed [tem_pkg::CHARGE_W-1:0] rsp_net_charge
);

   import tem_pkg::*;

   // Sequencer
   state_type state_ff, state_in;
   logic [1:0] sel_ff, sel_in;          // which area: solar, charge, discharge, net

   // Latched sample
   logic [15:0]        bv_ff, bv_in, sv_ff, sv_in;
   logic signed [17:0] bi_ff, bi_in, si_ff, si_in;
   logic [31:0]        t_ff, t_in, dt_ff, dt_in;

   // Shared multiplier (registered product) and area register
   logic [17:0] mul_a;
   logic [31:0] mul_b;
   logic [49:0] mul_ff, mul_in;
   logic [65:0] area_ff, area_in;

   // Powers and trapezoid heights (sum of both ends, as magnitudes)
   logic signed [34:0] ps_ff, ps_in;
   logic [33:0]        mag_ff [4];
   logic [33:0]        mag_in [4];
   logic               sneg_ff, sneg_in, ineg_ff, ineg_in;

   // Running totals
   logic [62:0]        solar_ff, solar_in, charge_ff, charge_in, dis_ff, dis_in;
   logic signed [63:0] bal_ff, bal_in;

   // History
   logic signed [34:0] last_ps_ff, last_ps_in;
   logic [33:0]        last_pc_ff, last_pc_in, last_pd_ff, last_pd_in;
   logic signed [17:0] last_bi_ff, last_bi_in;
   logic [31:0]        last_time_ff, last_time_in;
   logic               have_prev_ff, have_prev_in;

   status_type status_ff, status_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [62:0]        rsp_solar_ff, rsp_solar_in, rsp_charge_ff, rsp_charge_in;
   logic [62:0]        rsp_dis_ff, rsp_dis_in;
   logic signed [63:0] rsp_net_ff, rsp_net_in;

   // Datapath helpers
   logic [17:0] si_abs, bi_abs;
   logic [34:0] ps_mag;
   logic [33:0] pb_mag, pc_new, pd_new, mag_sel;
   logic        charging;
   logic signed [35:0] ssum;
   logic [35:0] smag_full;
   logic [34:0] csum, dsum;
   logic signed [18:0] isum;
   logic [18:0] imag;
   logic [62:0] sat_mag, acc_u, u_res;
   logic        neg_u;
   logic [64:0] delta65, sum65;
   logic [63:0] s_res;
   logic        rsp_load;

   assign si_abs   = si_ff[17] ? 18'(-si_ff) : 18'(si_ff);
   assign bi_abs   = bi_ff[17] ? 18'(-bi_ff) : 18'(bi_ff);
   assign ps_mag   = {1'b0, mul_ff[33:0]};
   assign pb_mag   = mul_ff[33:0];
   // battery power is positive only for a positive current
   assign charging = !bi_ff[17] && (bi_ff != '0);
   assign pc_new   = charging ? pb_mag : '0;
   assign pd_new   = charging ? '0 : pb_mag;

   assign ssum      = {last_ps_ff[34], last_ps_ff} + {ps_ff[34], ps_ff};
   assign smag_full = ssum[35] ? 36'(-ssum) : 36'(ssum);
   assign csum      = {1'b0, last_pc_ff} + {1'b0, pc_new};
   assign dsum      = {1'b0, last_pd_ff} + {1'b0, pd_new};
   assign isum      = {last_bi_ff[17], last_bi_ff} + {bi_ff[17], bi_ff};
   assign imag      = isum[18] ? 19'(-isum) : 19'(isum);

   assign mag_sel = mag_ff[sel_ff];
   assign mul_in  = {32'd0, mul_a} * {18'd0, mul_b};

   // Area clamp, then saturating accumulate into the selected total
   assign sat_mag = (area_ff[65:63] != '0) ? ENERGY_MAX : area_ff[62:0];
   always_comb begin
      unique case (sel_ff)
         2'd1:    acc_u = charge_ff;
         2'd2:    acc_u = dis_ff;
         default: acc_u = solar_ff;
      endcase
   end
   assign neg_u = (sel_ff == 2'd0) && sneg_ff;
   always_comb begin
      if (neg_u) begin
         u_res = (sat_mag >= acc_u) ? '0 : acc_u - sat_mag;
      end else begin
         u_res = (sat_mag >= ENERGY_MAX - acc_u) ? ENERGY_MAX : acc_u + sat_mag;
      end
   end
   assign delta65 = ineg_ff ? 65'(-{2'b00, sat_mag}) : {2'b00, sat_mag};
   assign sum65   = {bal_ff[63], bal_ff} + delta65;
   always_comb begin
      if (sum65[64] != sum65[63]) begin
         s_res = sum65[64] ? CHARGE_MIN : CHARGE_MAX;
      end else begin
         s_res = sum65[63:0];
      end
   end

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      bv_in        = bv_ff;
      bi_in        = bi_ff;
      sv_in        = sv_ff;
      si_in        = si_ff;
      t_in         = t_ff;
      dt_in        = dt_ff;
      area_in      = area_ff;
      ps_in        = ps_ff;
      mag_in       = mag_ff;
      sneg_in      = sneg_ff;
      ineg_in      = ineg_ff;
      solar_in     = solar_ff;
      charge_in    = charge_ff;
      dis_in       = dis_ff;
      bal_in       = bal_ff;
      last_ps_in   = last_ps_ff;
      last_pc_in   = last_pc_ff;
      last_pd_in   = last_pd_ff;
      last_bi_in   = last_bi_ff;
      last_time_in = last_time_ff;
      have_prev_in = have_prev_ff;
      status_in    = status_ff;
      mul_a        = '0;
      mul_b        = '0;
      req_ready    = 1'b0;
      rsp_load     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               bv_in = req_battery_voltage;
               bi_in = req_battery_current;
               sv_in = req_solar_voltage;
               si_in = req_solar_current;
               t_in  = req_sample_time;
               dt_in = req_sample_time - last_time_ff;   // wraps modulo 2^32
               if (req_op == OP_CLEAR) begin
                  solar_in     = '0;
                  charge_in    = '0;
                  dis_in       = '0;
                  bal_in       = '0;
                  last_ps_in   = '0;
                  last_pc_in   = '0;
                  last_pd_in   = '0;
                  last_bi_in   = '0;
                  last_time_in = '0;
                  have_prev_in = 1'b0;
                  status_in    = ST_CLEARED;
                  state_in     = S_DONE;
               end else begin
                  state_in = S_POWER_S;
               end
            end
         end
         S_POWER_S: begin
            mul_a    = si_abs;
            mul_b    = {16'd0, sv_ff};
            state_in = S_POWER_B;
         end
         S_POWER_B: begin
            mul_a    = bi_abs;
            mul_b    = {16'd0, bv_ff};
            ps_in    = si_ff[17] ? -$signed(ps_mag) : $signed(ps_mag);
            state_in = S_SUMS;
         end
         S_SUMS: begin
            if (have_prev_ff && (dt_ff == '0)) begin
               status_in = ST_SKIP;
               state_in  = S_DONE;
            end else begin
               last_ps_in   = ps_ff;
               last_pc_in   = pc_new;
               last_pd_in   = pd_new;
               last_bi_in   = bi_ff;
               last_time_in = t_ff;
               have_prev_in = 1'b1;
               if (!have_prev_ff) begin
                  status_in = ST_PRIMED;
                  state_in  = S_DONE;
               end else begin
                  mag_in[0] = smag_full[33:0];
                  mag_in[1] = csum[33:0];
                  mag_in[2] = dsum[33:0];
                  mag_in[3] = {15'd0, imag};
                  sneg_in   = ssum[35];
                  ineg_in   = isum[18];
                  sel_in    = 2'd0;
                  status_in = ST_INTEG;
                  state_in  = S_MUL_LO;
               end
            end
         end
         S_MUL_LO: begin
            mul_a    = {1'b0, mag_sel[16:0]};
            mul_b    = dt_ff;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            mul_a    = {1'b0, mag_sel[33:17]};
            mul_b    = dt_ff;
            area_in  = {16'd0, mul_ff};
            state_in = S_ADD;
         end
         S_ADD: begin
            area_in  = area_ff + {mul_ff[48:0], 17'd0};
            state_in = S_ACCUM;
         end
         S_ACCUM: begin
            unique case (sel_ff)
               2'd0: solar_in  = u_res;
               2'd1: charge_in = u_res;
               2'd2: dis_in    = u_res;
               2'd3: bal_in    = s_res;
            endcase
            if (sel_ff == 2'd3) begin
               state_in = S_DONE;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = S_MUL_LO;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output register: holds a finished result while the next sample is taken
   always_comb begin
      rsp_valid_in  = rsp_load || (rsp_valid_ff && !rsp_ready);
      rsp_status_in = rsp_load ? status_ff : rsp_status_ff;
      rsp_solar_in  = rsp_load ? solar_ff  : rsp_solar_ff;
      rsp_charge_in = rsp_load ? charge_ff : rsp_charge_ff;
      rsp_dis_in    = rsp_load ? dis_ff    : rsp_dis_ff;
      rsp_net_in    = rsp_load ? bal_ff    : rsp_net_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         solar_ff     <= '0;
         charge_ff    <= '0;
         dis_ff       <= '0;
         bal_ff       <= '0;
         last_ps_ff   <= '0;
         last_pc_ff   <= '0;
         last_pd_ff   <= '0;
         last_bi_ff   <= '0;
         last_time_ff <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         solar_ff     <= solar_in;
         charge_ff    <= charge_in;
         dis_ff       <= dis_in;
         bal_ff       <= bal_in;
         last_ps_ff   <= last_ps_in;
         last_pc_ff   <= last_pc_in;
         last_pd_ff   <= last_pd_in;
         last_bi_ff   <= last_bi_in;
         last_time_ff <= last_time_in;
         have_prev_ff <= have_prev_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff        <= sel_in;
      bv_ff         <= bv_in;
      bi_ff         <= bi_in;
      sv_ff         <= sv_in;
      si_ff         <= si_in;
      t_ff          <= t_in;
      dt_ff         <= dt_in;
      mul_ff        <= mul_in;
      area_ff       <= area_in;
      ps_ff         <= ps_in;
      mag_ff        <= mag_in;
      sneg_ff       <= sneg_in;
      ineg_ff       <= ineg_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_solar_ff  <= rsp_solar_in;
      rsp_charge_ff <= rsp_charge_in;
      rsp_dis_ff    <= rsp_dis_in;
      rsp_net_ff    <= rsp_net_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_solar_energy     = rsp_solar_ff;
   assign rsp_charge_energy    = rsp_charge_ff;
   assign rsp_discharge_energy = rsp_dis_ff;
   assign rsp_net_charge       = rsp_net_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/tem_checker.sv
`default_nettype none

module tem_assertions (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 req_valid,
   input wire                                 req_ready,
   input wire                                 req_op,
   input wire  [tem_pkg::VOLT_W-1:0]          req_battery_voltage,
   input wire  signed [tem_pkg::CURR_W-1:0]   req_battery_current,
   input wire  [tem_pkg::VOLT_W-1:0]          req_solar_voltage,
   input wire  signed [tem_pkg::CURR_W-1:0]   req_solar_current,
   input wire  [tem_pkg::TIME_W-1:0]          req_sample_time,
   input wire                                 rsp_valid,
   input wire                                 rsp_ready,
   input wire  [tem_pkg::STATUS_W-1:0]        rsp_status,
   input wire  [tem_pkg::ENERGY_W-1:0]        rsp_solar_energy,
   input wire  [tem_pkg::ENERGY_W-1:0]        rsp_charge_energy,
   input wire  [tem_pkg::ENERGY_W-1:0]        rsp_discharge_energy,
   input wire  signed [tem_pkg::CHARGE_W-1:0] rsp_net_charge
);

   import tem_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_solar_energy) && $stable(rsp_net_charge))
      else $error("result changed while stalled");

   // a clear reports all totals at zero
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_CLEARED) |-> (rsp_solar_energy == '0)
         && (rsp_charge_energy == '0) && (rsp_discharge_energy == '0)
         && (rsp_net_charge == '0))
      else $error("clear reported nonzero totals");

   // one transaction at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted back to back");

endmodule

bind trapezoid_energy_meter tem_assertions u_tem_assertions (.*);

`default_nettype wire

FILE: test/tem_checker.sv
`timescale 1ns / 1ps

module tem_checker (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   input  wire                                 req_ready,
   input  wire                                 req_op,
   input  wire  [tem_pkg::VOLT_W-1:0]          req_battery_voltage,
   input  wire  signed [tem_pkg::CURR_W-1:0]   req_battery_current,
   input  wire  [tem_pkg::VOLT_W-1:0]          req_solar_voltage,
   input  wire  signed [tem_pkg::CURR_W-1:0]   req_solar_current,
   input  wire  [tem_pkg::TIME_W-1:0]          req_sample_time,
   input  wire                                 rsp_valid,
   input  wire                                 rsp_ready,
   input  wire  [tem_pkg::STATUS_W-1:0]        rsp_status,
   input  wire  [tem_pkg::ENERGY_W-1:0]        rsp_solar_energy,
   input  wire  [tem_pkg::ENERGY_W-1:0]        rsp_charge_energy,
   input  wire  [tem_pkg::ENERGY_W-1:0]        rsp_discharge_energy,
   input  wire  signed [tem_pkg::CHARGE_W-1:0] rsp_net_charge,
   output int                                  error_count,
   output int                                  pending_count,
   output int                                  checked_count,
   output int                                  integrated_count,
   output int                                  skipped_count
);

   typedef struct packed {
      logic [tem_pkg::STATUS_W-1:0] status;
      logic [tem_pkg::ENERGY_W-1:0] solar;
      logic [tem_pkg::ENERGY_W-1:0] charge;
      logic [tem_pkg::ENERGY_W-1:0] discharge;
      logic [tem_pkg::CHARGE_W-1:0] net;
   } meter_totals_type;

   meter_totals_type expected_totals[$];

   // predicted meter state
   logic [62:0]        solar_acc;
   logic [62:0]        charge_acc;
   logic [62:0]        discharge_acc;
   logic signed [63:0] balance_acc;
   logic signed [34:0] prev_solar_pw;
   logic [33:0]        prev_charge_pw;
   logic [33:0]        prev_discharge_pw;
   logic signed [17:0] prev_batt_ma;
   logic [31:0]        prev_stamp;
   logic               primed;

   function automatic void clear_meter();
      solar_acc         = '0;
      charge_acc        = '0;
      discharge_acc     = '0;
      balance_acc       = '0;
      prev_solar_pw     = '0;
      prev_charge_pw    = '0;
      prev_discharge_pw = '0;
      prev_batt_ma      = '0;
      prev_stamp        = '0;
      primed            = 1'b0;
   endfunction

   // magnitude * interval, clipped to 2^63-1
   function automatic logic [62:0] trapezoid_area(input logic [63:0] mag,
                                                  input logic [31:0] dt);
      logic [127:0] prod;
      prod = {64'd0, mag} * {96'd0, dt};
      return (prod > {65'd0, tem_pkg::ENERGY_MAX}) ? tem_pkg::ENERGY_MAX : prod[62:0];
   endfunction

   function automatic logic [62:0] add_energy(input logic [62:0] acc, input logic neg,
                                              input logic [62:0] mag);
      logic [63:0] sum;
      if (neg)
         return (mag >= acc) ? '0 : acc - mag;
      sum = {1'b0, acc} + {1'b0, mag};
      return (sum >= {1'b0, tem_pkg::ENERGY_MAX}) ? tem_pkg::ENERGY_MAX : sum[62:0];
   endfunction

   function automatic logic [63:0] add_charge(input logic signed [63:0] acc,
                                              input logic signed [63:0] delta);
      logic signed [64:0] sum;
      sum = acc + delta;
      if (sum > $signed({1'b0, tem_pkg::CHARGE_MAX}))
         return tem_pkg::CHARGE_MAX;
      if (sum < $signed({1'b1, tem_pkg::CHARGE_MIN}))
         return tem_pkg::CHARGE_MIN;
      return sum[63:0];
   endfunction

   // advances the predicted meter by one transaction, returns the totals it reports
   function automatic meter_totals_type advance_meter(input logic op,
                                                      input logic [15:0] bv,
                                                      input logic signed [17:0] bi,
                                                      input logic [15:0] sv,
                                                      input logic signed [17:0] si,
                                                      input logic [31:0] stamp);
      meter_totals_type   res;
      logic signed [34:0] ps;
      logic signed [34:0] pb;
      logic signed [34:0] pb_neg;
      logic [33:0]        pc;
      logic [33:0]        pd;
      logic [31:0]        dt;
      logic signed [35:0] ssum;
      logic [35:0]        smag;
      logic signed [18:0] isum;
      logic signed [63:0] q_area;
      logic [1:0]         st;
      ps     = $signed({1'b0, sv}) * si;
      pb     = $signed({1'b0, bv}) * bi;
      pb_neg = -pb;
      pc     = (pb > 0) ? pb[33:0] : '0;
      pd     = (pb > 0) ? '0 : pb_neg[33:0];
      dt     = stamp - prev_stamp;
      if (op == tem_pkg::OP_CLEAR) begin
         clear_meter();
         st = tem_pkg::ST_CLEARED;
      end else if (!primed) begin
         st = tem_pkg::ST_PRIMED;
      end else if (dt == 0) begin
         st = tem_pkg::ST_SKIP;
      end else begin
         ssum = prev_solar_pw + ps;
         smag = (ssum < 0) ? -ssum : ssum;
         solar_acc = add_energy(solar_acc, ssum < 0, trapezoid_area({28'd0, smag}, dt));
         charge_acc = add_energy(charge_acc, 1'b0,
            trapezoid_area({30'd0, prev_charge_pw} + {30'd0, pc}, dt));
         discharge_acc = add_energy(discharge_acc, 1'b0,
            trapezoid_area({30'd0, prev_discharge_pw} + {30'd0, pd}, dt));
         isum   = prev_batt_ma + bi;
         q_area = isum * $signed({1'b0, dt});
         balance_acc = add_charge(balance_acc, q_area);
         st = tem_pkg::ST_INTEG;
      end
      if (op != tem_pkg::OP_CLEAR && st != tem_pkg::ST_SKIP) begin
         prev_solar_pw     = ps;
         prev_charge_pw    = pc;
         prev_discharge_pw = pd;
         prev_batt_ma      = bi;
         prev_stamp        = stamp;
         primed            = 1'b1;
      end
      res.status    = st;
      res.solar     = solar_acc;
      res.charge    = charge_acc;
      res.discharge = discharge_acc;
      res.net       = balance_acc;
      return res;
   endfunction

   task automatic flag_mismatch(input string what, input logic [63:0] want_v,
                                input logic [63:0] got_v);
      error_count++;
      if (error_count <= 10)
         $display("%0t: result %0d, %s: expected %h, got %h",
                  $time, checked_count, what, want_v, got_v);
   endtask

   always @(posedge clock) begin : watch
      meter_totals_type got;
      meter_totals_type want;
      if (reset) begin
         clear_meter();
         expected_totals.delete();
         pending_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.status    = rsp_status;
            got.solar     = rsp_solar_energy;
            got.charge    = rsp_charge_energy;
            got.discharge = rsp_discharge_energy;
            got.net       = rsp_net_charge;
            checked_count++;
            if (expected_totals.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: result %0d arrived with nothing outstanding (status %0d)",
                           $time, checked_count, got.status);
            end else begin
               want = expected_totals.pop_front();
               if (want.status == tem_pkg::ST_INTEG)
                  integrated_count++;
               if (want.status == tem_pkg::ST_SKIP)
                  skipped_count++;
               if (got.status !== want.status)
                  flag_mismatch("status", 64'(want.status), 64'(got.status));
               if (got.solar !== want.solar)
                  flag_mismatch("solar_energy", 64'(want.solar), 64'(got.solar));
               if (got.charge !== want.charge)
                  flag_mismatch("charge_energy", 64'(want.charge), 64'(got.charge));
               if (got.discharge !== want.discharge)
                  flag_mismatch("discharge_energy", 64'(want.discharge),
                                64'(got.discharge));
               if (got.net !== want.net)
                  flag_mismatch("net_charge", want.net, got.net);
            end
         end
         if (req_valid && req_ready)
            expected_totals.push_back(advance_meter(req_op, req_battery_voltage,
               req_battery_current, req_solar_voltage, req_solar_current,
               req_sample_time));
         pending_count = expected_totals.size();
      end
   end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int RANDOM_ITEMS = 1550;
   // the net-charge rails lie some 8192 full-scale steps away; a short ramp still
   // builds totals far beyond 32 bits in both directions
   localparam int RAMP_STEPS   = 60;
   localparam int DRAIN_CYCLES = 40;

   localparam logic signed [17:0] AMPS_MAX = 18'sh1FFFF;
   localparam logic signed [17:0] AMPS_MIN = 18'sh20000;

   // receiver stall patterns
   localparam int RX_OPEN    = 0;
   localparam int RX_COIN    = 1;
   localparam int RX_TRICKLE = 2;
   localparam int RX_SPARSE  = 3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 req_valid           = 1'b0;
   logic                                 req_ready;
   logic                                 req_op              = tem_pkg::OP_SAMPLE;
   logic [tem_pkg::VOLT_W-1:0]           req_battery_voltage = '0;
   logic signed [tem_pkg::CURR_W-1:0]    req_battery_current = '0;
   logic [tem_pkg::VOLT_W-1:0]           req_solar_voltage   = '0;
   logic signed [tem_pkg::CURR_W-1:0]    req_solar_current   = '0;
   logic [tem_pkg::TIME_W-1:0]           req_sample_time     = '0;

   logic                                 rsp_valid;
   logic                                 rsp_ready           = 1'b0;
   logic [tem_pkg::STATUS_W-1:0]         rsp_status;
   logic [tem_pkg::ENERGY_W-1:0]         rsp_solar_energy;
   logic [tem_pkg::ENERGY_W-1:0]         rsp_charge_energy;
   logic [tem_pkg::ENERGY_W-1:0]         rsp_discharge_energy;
   logic signed [tem_pkg::CHARGE_W-1:0]  rsp_net_charge;

   int error_count;
   int pending_count;
   int checked_count;
   int integrated_count;
   int skipped_count;

   int          items_sent  = 0;
   int          clears_sent = 0;
   int unsigned cycle_count = 0;
   logic        flush_mode  = 1'b0;   // receiver never stalls during the ramps

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   trapezoid_energy_meter i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_battery_voltage  (req_battery_voltage),
      .req_battery_current  (req_battery_current),
      .req_solar_voltage    (req_solar_voltage),
      .req_solar_current    (req_solar_current),
      .req_sample_time      (req_sample_time),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_solar_energy     (rsp_solar_energy),
      .rsp_charge_energy    (rsp_charge_energy),
      .rsp_discharge_energy (rsp_discharge_energy),
      .rsp_net_charge       (rsp_net_charge)
   );

   // watches both channels, predicts every result and compares
   tem_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_battery_voltage  (req_battery_voltage),
      .req_battery_current  (req_battery_current),
      .req_solar_voltage    (req_solar_voltage),
      .req_solar_current    (req_solar_current),
      .req_sample_time      (req_sample_time),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_solar_energy     (rsp_solar_energy),
      .rsp_charge_energy    (rsp_charge_energy),
      .rsp_discharge_energy (rsp_discharge_energy),
      .rsp_net_charge       (rsp_net_charge),
      .error_count          (error_count),
      .pending_count        (pending_count),
      .checked_count        (checked_count),
      .integrated_count     (integrated_count),
      .skipped_count        (skipped_count)
   );

   // hard stop in case the block hangs or drops a result
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_count);
         $display("[trapezoid_energy_meter] ERROR");
         $finish;
      end
   end

   // Receiver: switches at random between stall patterns so that
   // back-pressure hits the block in every phase of its multiply sequence.
   int rx_mode   = RX_OPEN;
   int rx_left   = 0;
   int rx_period = 2;
   int rx_phase  = 0;

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode   <= $urandom_range(RX_OPEN, RX_SPARSE);
         rx_left   <= $urandom_range(64, 256);
         rx_period <= $urandom_range(2, 24);
      end else begin
         rx_left <= rx_left - 1;
      end
      rx_phase <= (rx_phase + 1 >= rx_period) ? 0 : rx_phase + 1;
      if (flush_mode) begin
         rsp_ready <= 1'b1;
      end else begin
         case (rx_mode)
            RX_OPEN:    rsp_ready <= 1'b1;
            RX_COIN:    rsp_ready <= 1'($urandom_range(0, 1));
            RX_TRICKLE: rsp_ready <= (rx_phase == 0);
            default:    rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance with
   // valid still high, so a burst keeps valid asserted between transactions.
   task automatic issue(input logic op, input logic [15:0] bv, input logic signed [17:0] bi,
                        input logic [15:0] sv, input logic signed [17:0] si,
                        input logic [31:0] stamp);
      req_valid           <= 1'b1;
      req_op              <= op;
      req_battery_voltage <= bv;
      req_battery_current <= bi;
      req_solar_voltage   <= sv;
      req_solar_current   <= si;
      req_sample_time     <= stamp;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
      if (op == tem_pkg::OP_CLEAR)
         clears_sent++;
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // hold off the sender until every outstanding result has been seen
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   function automatic logic [15:0] pick_volt();
      case ($urandom_range(0, 7))
         0:       return 16'hFFFF;
         1:       return 16'h0000;
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   function automatic logic signed [17:0] pick_amps();
      case ($urandom_range(0, 9))
         0:       return AMPS_MAX;
         1:       return AMPS_MIN;
         2:       return 18'sd0;
         3:       return -18'sd1;
         4, 5:    return 18'($urandom_range(0, 2000) - 1000);
         default: return 18'($urandom_range(0, 18'h3FFFF));
      endcase
   endfunction

   // time step between samples: mostly short, sometimes none, sometimes huge
   function automatic logic [31:0] pick_interval();
      case ($urandom_range(0, 15))
         0:                return 32'd0;
         1:                return $urandom;
         2:                return 32'hFFFF_FFFF;
         3, 4, 5, 6, 7, 8: return $urandom_range(1, 20);
         default:          return $urandom_range(1, 5000);
      endcase
   endfunction

   initial begin : stimulus
      logic [31:0] stamp_ms;
      int          directed_count;
      int          ramp_count;
      int          random_count;
      int          burst;
      int          mark;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---------------- directed transactions ----------------
      // priming at timestamp zero, every field at its maximum
      issue(tem_pkg::OP_SAMPLE, 16'hFFFF, AMPS_MAX, 16'hFFFF, AMPS_MAX, 32'd0);
      // same timestamp: zero interval, nothing moves
      issue(tem_pkg::OP_SAMPLE, 16'h1234, -18'sd5, 16'h4321, 18'sd7, 32'd0);
      // longest interval, both currents at the negative rail: charge area saturates
      issue(tem_pkg::OP_SAMPLE, 16'hFFFF, AMPS_MIN, 16'hFFFF, AMPS_MIN, 32'hFFFF_FFFF);
      // timestamp wraps past zero, all-zero sample
      issue(tem_pkg::OP_SAMPLE, 16'd0, 18'sd0, 16'd0, 18'sd0, 32'd5);
      // clear while every field is set
      issue(tem_pkg::OP_CLEAR, 16'hFFFF, AMPS_MIN, 16'hFFFF, AMPS_MAX, 32'hFFFF_FFFF);
      // prime just below the wrap, then integrate across it
      issue(tem_pkg::OP_SAMPLE, 16'd12000, 18'sd1500, 16'd18000, 18'sd2000, 32'hFFFF_FFF0);
      issue(tem_pkg::OP_SAMPLE, 16'd12100, -18'sd800, 16'd17500, 18'sd1900, 32'h0000_0010);
      // solar current reverses hard: negative area exceeds the total, which clamps at zero
      issue(tem_pkg::OP_SAMPLE, 16'd12050, -18'sd900, 16'hFFFF, AMPS_MIN, 32'h0001_0000);
      issue(tem_pkg::OP_SAMPLE, 16'd12050, -18'sd900, 16'hFFFF, AMPS_MIN, 32'h0002_0000);
      // repeated timestamp after integration
      issue(tem_pkg::OP_SAMPLE, 16'd1, 18'sd1, 16'd1, 18'sd1, 32'h0002_0000);
      // back-to-back clears
      issue(tem_pkg::OP_CLEAR, 16'd0, 18'sd0, 16'd0, 18'sd0, 32'd0);
      issue(tem_pkg::OP_CLEAR, 16'd0, 18'sd0, 16'd0, 18'sd0, 32'd0);
      // prime at the top of the time range, one millisecond over the wrap
      issue(tem_pkg::OP_SAMPLE, 16'hFFFF, AMPS_MAX, 16'd0, 18'sd0, 32'hFFFF_FFFF);
      issue(tem_pkg::OP_SAMPLE, 16'hFFFF, AMPS_MAX, 16'd0, 18'sd0, 32'h0000_0000);
      // zero voltage with full current: power is zero, charge still flows
      issue(tem_pkg::OP_SAMPLE, 16'd0, AMPS_MIN, 16'd1, 18'sd1, 32'd1);
      issue(tem_pkg::OP_SAMPLE, 16'd1, -18'sd1, 16'd1, -18'sd1, 32'd2);
      issue(tem_pkg::OP_SAMPLE, 16'hFFFF, 18'sd1, 16'hFFFF, -18'sd1, 32'd3);
      directed_count = items_sent;

      // let everything settle before the ramps
      wait_for_results();

      // ---------------- net charge ramps ----------------
      // Maximum current over maximum intervals drives net_charge far up, then far down.
      flush_mode <= 1'b1;
      issue(tem_pkg::OP_CLEAR, 16'd0, 18'sd0, 16'd0, 18'sd0, 32'd0);
      stamp_ms = $urandom;
      issue(tem_pkg::OP_SAMPLE, pick_volt(), AMPS_MAX, pick_volt(), pick_amps(), stamp_ms);
      repeat (RAMP_STEPS) begin
         stamp_ms += 32'hFFFF_FFFF;
         issue(tem_pkg::OP_SAMPLE, pick_volt(), AMPS_MAX, pick_volt(), pick_amps(),
               stamp_ms);
      end
      // reverse the current for a couple of steps
      repeat (2) begin
         stamp_ms += 32'hFFFF_FFFF;
         issue(tem_pkg::OP_SAMPLE, pick_volt(), AMPS_MIN, pick_volt(), pick_amps(),
               stamp_ms);
      end
      issue(tem_pkg::OP_CLEAR, pick_volt(), pick_amps(), pick_volt(), pick_amps(),
            $urandom);
      issue(tem_pkg::OP_SAMPLE, pick_volt(), AMPS_MIN, pick_volt(), pick_amps(), stamp_ms);
      repeat (RAMP_STEPS) begin
         stamp_ms += 32'hFFFF_FFFF;
         issue(tem_pkg::OP_SAMPLE, pick_volt(), AMPS_MIN, pick_volt(), pick_amps(),
               stamp_ms);
      end
      // and back up for a couple of steps
      repeat (2) begin
         stamp_ms += 32'hFFFF_FFFF;
         issue(tem_pkg::OP_SAMPLE, pick_volt(), AMPS_MAX, pick_volt(), pick_amps(),
               stamp_ms);
      end
      wait_for_results();
      flush_mode <= 1'b0;
      ramp_count = items_sent - directed_count;

      // ---------------- random traffic ----------------
      // Mostly a running sample stream with random content and intervals; occasional
      // clears, backward or huge time jumps, and forced wraps act as noise.
      mark = items_sent;
      stamp_ms = $urandom;
      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            if ($urandom_range(0, 39) == 0) begin
               issue(tem_pkg::OP_CLEAR, pick_volt(), pick_amps(), pick_volt(), pick_amps(),
                     $urandom);
            end else begin
               if ($urandom_range(0, 99) == 0)
                  stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 50);
               stamp_ms += pick_interval();
               issue(tem_pkg::OP_SAMPLE, pick_volt(), pick_amps(), pick_volt(), pick_amps(),
                     stamp_ms);
            end
            random_count++;
         end
         case ($urandom_range(0, 9))
            0:       wait_for_results();
            1, 2, 3: ;                                   // keep streaming
            4:       idle_for($urandom_range(20, 40));
            default: idle_for($urandom_range(1, 8));
         endcase
      end
      random_count = items_sent - mark;

      // ---------------- wrap up ----------------
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d transactions: %0d directed, %0d on the net-charge ramps, %0d random;",
               items_sent, directed_count, ramp_count, random_count);
      $display("%0d results checked (%0d integrating, %0d zero-interval, %0d clears), %0d errors",
               checked_count, integrated_count, skipped_count, clears_sent, error_count);
      if (error_count == 0)
         $display("[trapezoid_energy_meter] OK");
      else
         $display("[trapezoid_energy_meter] ERROR");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/tem_pkg.sv
hw/rtl/trapezoid_energy_meter.sv
hw/rtl/tem_checker.sv
test/tem_checker.sv
test/tb.sv
